/* hw/rtl/ssd_pkg.sv */
package ssd_pkg;

    // Display geometry
    localparam int NUM_DIGITS = 13;
    localparam int DIG_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    // Request modes
    localparam logic [2:0] MODE_TICK    = 3'd0;
    localparam logic [2:0] MODE_CHAR    = 3'd1;
    localparam logic [2:0] MODE_RAW     = 3'd2;
    localparam logic [2:0] MODE_DOT_ON  = 3'd3;
    localparam logic [2:0] MODE_DOT_OFF = 3'd4;

    // Configuration register indexes
    localparam logic CFG_RIGHT_SCREEN = 1'b0;
    localparam logic CFG_LEFT_SCREEN  = 1'b1;

    // Dimming phases
    localparam logic [2:0] PHASE_SCAN  = 3'd4;
    localparam logic [2:0] PHASE_DRIVE = 3'd7;

    // Blink window
    localparam logic [9:0] BLINK_WRAP = 10'd600;
    localparam logic [9:0] BLINK_SET  = 10'd400;
    localparam logic [9:0] BLINK_CLR  = 10'd200;

    // Character codes
    localparam logic [7:0] CHAR_MAX   = 8'd14;
    localparam logic [3:0] CHAR_BLANK = 4'd15;
    localparam logic [3:0] CHAR_EIGHT = 4'd8;

    // Segment table selectors
    localparam logic [1:0] TBL_MAIN  = 2'd0;
    localparam logic [1:0] TBL_GEAR  = 2'd1;
    localparam logic [1:0] TBL_RIGHT = 2'd2;

    localparam logic [7:0] GLYPH_MAIN [16] = '{
        8'hF5, 8'h14, 8'hB9, 8'h3D, 8'h5C, 8'h6D, 8'hCD, 8'h34,
        8'hFD, 8'h7C, 8'h0A, 8'h08, 8'h00, 8'hC1, 8'hE8, 8'h00
    };
    localparam logic [7:0] GLYPH_GEAR [16] = '{
        8'h77, 8'h41, 8'h6E, 8'h6B, 8'h59, 8'h3B, 8'h1F, 8'h61,
        8'h7F, 8'h79, 8'h0D, 8'h08, 8'h00, 8'h16, 8'h3C, 8'h00
    };
    localparam logic [7:0] GLYPH_RIGHT [16] = '{
        8'hFA, 8'h82, 8'hB9, 8'hAB, 8'hC3, 8'h6B, 8'h5B, 8'hA2,
        8'hFB, 8'hE3, 8'h04, 8'h01, 8'h00, 8'h58, 8'h71, 8'h00
    };
    localparam logic [3:0] POS_MAP [16] = '{
        4'd0, 4'd1, 4'd2, 4'd7, 4'd9, 4'd10, 4'd3, 4'd4,
        4'd5, 4'd6, 4'd11, 4'd12, 4'd8, 4'd13, 4'd14, 4'd15
    };

    // Work handed from the front to the back
    typedef struct packed {
        logic       drive;
        logic [7:0] seg;
        logic [3:0] mux;
    } job_t;

    // Result item held in the output queue
    typedef struct packed {
        logic       action;
        logic [7:0] seg_bits;
        logic [7:0] menu_bits;
        logic [3:0] mux_select;
    } result_t;

    function automatic logic [7:0] glyph(input logic [1:0] tbl, input logic [3:0] code);
        logic [7:0] g;
        case (tbl)
            TBL_GEAR:  g = GLYPH_GEAR[code];
            TBL_RIGHT: g = GLYPH_RIGHT[code];
            default:   g = GLYPH_MAIN[code];
        endcase
        return g;
    endfunction

    function automatic logic [1:0] digit_table(input logic [3:0] d);
        logic [1:0] t;
        case (d)
            4'd8, 4'd9, 4'd10, 4'd11: t = TBL_RIGHT;
            4'd12:                    t = TBL_GEAR;
            default:                  t = TBL_MAIN;
        endcase
        return t;
    endfunction

endpackage

/* hw/rtl/seven_segment_scan_driver.sv */
// Seven-segment scan driver for a multiplexed display.
// Input channel (push/full): one request per cycle unless full, carrying
// mode, digit and value. Mode tick advances the dimming phase; the char,
// raw and dot modes set a digit's character, raw byte or dot; no result.
// Result channel (empty/pop): the oldest result sits on action, seg_bits,
// menu_bits and mux_select while empty is low; pop takes it.
// Configuration channel (cfg_valid/cfg_ready, always ready): cfg_index 0
// sets the always-lit menu bit, 1 sets the blinking menu bit.
// Throughput: one request per cycle, sustained, while the result side pops.
// A tick that yields a result is written into the front-to-back job queue
// when it is accepted, then into the output queue once that has room; it
// shows with empty low from there and can then be popped.
// Stall: a two-entry job queue and a two-entry output queue absorb a
// stalled receiver; full rises once both are taken and drops as pops resume.
// Reset: phase, scan digit and blink counter clear, every digit shows a raw
// byte of zero with no dot, both menu bits select bit 0, queues empty.
module seven_segment_scan_driver (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [2:0] mode,
    input  logic [3:0] digit,
    input  logic [7:0] value,
    output logic       empty,
    input  logic       pop,
    output logic       action,
    output logic [7:0] seg_bits,
    output logic [7:0] menu_bits,
    output logic [3:0] mux_select,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [2:0] cfg_data
);
    import ssd_pkg::*;

    job_t q_din, q_dout;
    logic q_push, q_pop, q_full, q_empty;

    ssd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .mode     (mode),
        .digit    (digit),
        .value    (value),
        .q_full   (q_full),
        .full     (full),
        .job_push (q_push),
        .job      (q_din)
    );

    ssd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .pop   (q_pop),
        .dout  (q_dout),
        .full  (q_full),
        .empty (q_empty)
    );

    ssd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .job_empty  (q_empty),
        .job        (q_dout),
        .job_pop    (q_pop),
        .pop        (pop),
        .empty      (empty),
        .action     (action),
        .seg_bits   (seg_bits),
        .menu_bits  (menu_bits),
        .mux_select (mux_select)
    );

endmodule

/* hw/rtl/ssd_front.sv */
module ssd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [2:0]        mode,
    input  logic [3:0]        digit,
    input  logic [7:0]        value,
    input  logic              q_full,
    output logic              full,
    output logic              job_push,
    output ssd_pkg::job_t     job
);
    import ssd_pkg::*;

    logic [2:0]  phase_reg, phase_next;
    logic [3:0]  scan_reg, scan_next;
    logic [3:0]  char_codes_reg [NUM_DIGITS];
    logic [7:0]  raw_bytes_reg  [NUM_DIGITS];
    logic        raw_valid_reg  [NUM_DIGITS];
    logic        dot_flags_reg  [NUM_DIGITS];

    logic             accept;
    logic             store_en;
    logic [DIG_W-1:0] widx;
    logic [DIG_W-1:0] ridx;
    logic [2:0]       phase_inc;
    logic [3:0]       scan_adv;
    logic [3:0]       scan_sel;
    logic [1:0]       tbl;
    logic [7:0]       seg_byte;
    logic [3:0]       char_in;

    assign accept = push & ~q_full;
    assign full   = q_full;

    // Classify digit writes
    assign store_en = accept && (mode != MODE_TICK) && (mode <= MODE_DOT_OFF)
                      && (digit < 4'(NUM_DIGITS));
    assign widx     = digit[DIG_W-1:0];
    assign char_in  = (value > CHAR_MAX) ? CHAR_BLANK : value[3:0];

    // Look up the segment byte of the current scan digit
    assign ridx = scan_reg[DIG_W-1:0];
    assign tbl  = digit_table(scan_reg);
    always_comb
    begin
        seg_byte = raw_valid_reg[ridx] ? raw_bytes_reg[ridx]
                                       : glyph(tbl, char_codes_reg[ridx]);
        if (dot_flags_reg[ridx])
        begin
            seg_byte = seg_byte | ~glyph(tbl, CHAR_EIGHT);
        end
    end

    // Advance phase and scan digit on a tick, issue a job when one is due
    assign phase_inc = phase_reg + 3'd1;
    assign scan_adv  = (scan_reg >= 4'(NUM_DIGITS - 1)) ? 4'd0 : scan_reg + 4'd1;

    always_comb
    begin
        phase_next = phase_reg;
        scan_next  = scan_reg;
        scan_sel   = scan_reg;
        job_push   = 1'b0;
        job        = '0;
        if (accept && mode == MODE_TICK)
        begin
            if (phase_inc == PHASE_DRIVE)
            begin
                phase_next = 3'd0;
                job_push   = 1'b1;
                job.drive  = 1'b1;
                job.seg    = seg_byte;
            end
            else
            begin
                phase_next = phase_inc;
                if (phase_inc == PHASE_SCAN)
                begin
                    scan_next = scan_adv;
                    scan_sel  = scan_adv;
                end
                if (phase_inc >= PHASE_SCAN)
                begin
                    job_push = 1'b1;
                    job.mux  = POS_MAP[scan_sel] + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 3'd0;
            scan_reg  <= 4'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            scan_reg  <= scan_next;
        end
    end

    // Update the digit stores
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_DIGITS; i++)
            begin
                char_codes_reg[i] <= 4'd0;
                raw_bytes_reg[i]  <= 8'd0;
                raw_valid_reg[i]  <= 1'b1;
                dot_flags_reg[i]  <= 1'b0;
            end
        end
        else if (store_en)
        begin
            case (mode)
                MODE_CHAR:
                begin
                    char_codes_reg[widx] <= char_in;
                    raw_valid_reg[widx]  <= 1'b0;
                end
                MODE_RAW:
                begin
                    raw_bytes_reg[widx] <= value;
                    raw_valid_reg[widx] <= 1'b1;
                end
                MODE_DOT_ON:  dot_flags_reg[widx] <= 1'b1;
                MODE_DOT_OFF: dot_flags_reg[widx] <= 1'b0;
                default: ;
            endcase
        end
    end

endmodule

/* hw/rtl/ssd_queue.sv */
module ssd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ssd_pkg::job_t din,
    input  logic          pop,
    output ssd_pkg::job_t dout,
    output logic          full,
    output logic          empty
);
    import ssd_pkg::*;

    job_t       slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign dout    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // Hold the job payload
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

/* hw/rtl/ssd_back.sv */
module ssd_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_index,
    input  logic [2:0]    cfg_data,
    input  logic          job_empty,
    input  ssd_pkg::job_t job,
    output logic          job_pop,
    input  logic          pop,
    output logic          empty,
    output logic          action,
    output logic [7:0]    seg_bits,
    output logic [7:0]    menu_bits,
    output logic [3:0]    mux_select
);
    import ssd_pkg::*;

    logic [2:0] right_bit_reg, left_bit_reg;
    logic [9:0] blink_reg, blink_next;
    result_t    out_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    logic       room;
    logic       do_pop;
    logic [9:0] blink_base;
    logic [7:0] left_mask;
    logic [7:0] menu;
    result_t    res;

    // Take configuration writes at any time
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            right_bit_reg <= 3'd0;
            left_bit_reg  <= 3'd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_RIGHT_SCREEN: right_bit_reg <= cfg_data;
                CFG_LEFT_SCREEN:  left_bit_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pull a job whenever the output queue has room
    assign room    = (count_reg != 2'd2);
    assign job_pop = ~job_empty & room;
    assign do_pop  = pop & ~empty;

    // Build the menu byte and step the blink counter
    assign blink_base = (blink_reg == BLINK_WRAP) ? 10'd0 : blink_reg;
    assign left_mask  = 8'd1 << left_bit_reg;

    always_comb
    begin
        menu = 8'd1 << right_bit_reg;
        if (blink_base > BLINK_SET)
        begin
            menu = menu | left_mask;
        end
        else if (blink_base > BLINK_CLR && blink_base < BLINK_SET)
        begin
            menu = menu & ~left_mask;
        end
        blink_next = blink_reg;
        if (job_pop && job.drive)
        begin
            blink_next = blink_base + 10'd1;
        end
    end

    // Format the result
    always_comb
    begin
        res            = '0;
        res.action     = ~job.drive;
        res.seg_bits   = job.drive ? job.seg : 8'd0;
        res.menu_bits  = job.drive ? menu : 8'd0;
        res.mux_select = job.drive ? 4'd0 : job.mux;
    end

    always_comb
    begin
        count_next = count_reg;
        if (job_pop && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !job_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            out_reg[wr_ptr_reg] <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blink_reg  <= 10'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            blink_reg <= blink_next;
            if (job_pop)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    // Present the oldest result
    assign empty      = (count_reg == 2'd0);
    assign action     = out_reg[rd_ptr_reg].action;
    assign seg_bits   = out_reg[rd_ptr_reg].seg_bits;
    assign menu_bits  = out_reg[rd_ptr_reg].menu_bits;
    assign mux_select = out_reg[rd_ptr_reg].mux_select;

endmodule

/* hw/rtl/ssd_checker.sv */
module ssd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic       action,
    input logic [7:0] seg_bits,
    input logic [7:0] menu_bits,
    input logic [3:0] mux_select
);

    // A stalled result stays in place
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(seg_bits) && $stable(mux_select)))
        else $error("stalled result changed");

    // Blanking results carry no segment or menu bits
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && action) |-> (seg_bits == 8'd0 && menu_bits == 8'd0))
        else $error("blanking result drives segments");

    // Blanking selects a real mux line, driving selects none
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (action ? (mux_select != 4'd0) : (mux_select == 4'd0)))
        else $error("mux select does not match action");

    // Two drive results never follow back to back
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !action) |=> (empty || action))
        else $error("drive results adjacent");

    // Nothing waits right after reset
    assert property (@(posedge clk)
        $rose(rst_n) |-> (empty && !full))
        else $error("queues not empty after reset");

endmodule

bind seven_segment_scan_driver ssd_checker u_ssd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .action     (action),
    .seg_bits   (seg_bits),
    .menu_bits  (menu_bits),
    .mux_select (mux_select)
);
